// ----- hw/rtl/bbp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bbp_pkg
// types and constants shared by the bimodal branch predictor and its checker
// ----------------------------------------------------------------------------
package bbp_pkg;

  localparam int CounterEntries = 256;
  localparam int BufferEntries  = 64;

  localparam int PcW  = 32;
  localparam int TagW = 30;
  localparam int CtrW = 2;

  localparam logic [CtrW-1:0] CtrMax      = 2'd3;
  localparam logic [CtrW-1:0] CtrMin      = 2'd0;
  localparam logic [CtrW-1:0] CtrTakenMin = 2'd2;
  localparam logic [CtrW-1:0] CtrReset    = 2'd1;
  localparam logic [PcW-1:0]  PcStep      = 32'd4;

  typedef enum logic {
    ACT_PREDICT = 1'b0,
    ACT_UPDATE  = 1'b1
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [PcW-1:0]   pc;
    logic             was_taken;
    logic [PcW-1:0]   jump_target;
  } bbp_in_t;

  typedef struct packed {
    logic             predict_taken;
    logic             buffer_hit;
    logic [PcW-1:0]   next_pc;
  } bbp_out_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bimodal_branch_predictor_btb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bimodal_branch_predictor_btb_top
// 2-bit counter direction table and direct-mapped target buffer, both held
// in single-port-write synchronous memories with read-modify-write
// ----------------------------------------------------------------------------
// a predict transaction is captured with its memory reads, then its result
//   is registered; lookup waits while the result register is stalled
// only one transaction is in flight: a new one is accepted after the memory
//   read and the compute and write-back step of the last have finished
// reset: a clearing pass over max(COUNTER_ENTRIES, BUFFER_ENTRIES) addresses sets
//   every counter to weakly not taken and every buffer entry invalid;
//   in_stall_o stays high until it ends
module bimodal_branch_predictor_btb_top #(
  parameter int COUNTER_ENTRIES = bbp_pkg::CounterEntries,
  parameter int BUFFER_ENTRIES  = bbp_pkg::BufferEntries
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire bbp_pkg::bbp_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output bbp_pkg::bbp_out_t      out_data_o
);
  import bbp_pkg::*;

  localparam int CIW  = $clog2(COUNTER_ENTRIES);
  localparam int BIW  = $clog2(BUFFER_ENTRIES);
  localparam int MAXE = (COUNTER_ENTRIES > BUFFER_ENTRIES) ? COUNTER_ENTRIES
                                                           : BUFFER_ENTRIES;
  localparam int CLRW = $clog2(MAXE);

  localparam logic [CIW-1:0]  CMask    = CIW'(COUNTER_ENTRIES - 1);
  localparam logic [BIW-1:0]  BMask    = BIW'(BUFFER_ENTRIES - 1);
  localparam logic [CLRW:0]   CntDepth = (CLRW+1)'(COUNTER_ENTRIES);
  localparam logic [CLRW:0]   BufDepth = (CLRW+1)'(BUFFER_ENTRIES);
  localparam logic [CLRW-1:0] ClrLast  = CLRW'(MAXE - 1);

  typedef struct packed {
    logic            valid;
    logic [TagW-1:0] tag;
    logic [PcW-1:0]  target;
  } buf_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CLRW-1:0]   clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  bbp_out_t          out_data_q, out_data_d;
  bbp_in_t           req_q;

  logic [CtrW-1:0]   ctr_mem [COUNTER_ENTRIES];
  buf_entry_t        buf_mem [BUFFER_ENTRIES];
  logic [CtrW-1:0]   ctr_rd_q;
  buf_entry_t        buf_rd_q;

  logic              accept;
  logic [CIW-1:0]    ctr_ra, ctr_wa, ctr_req_idx;
  logic [BIW-1:0]    buf_ra, buf_wa, buf_req_idx;
  logic              ctr_we, buf_we;
  logic [CtrW-1:0]   ctr_wd, ctr_new;
  buf_entry_t        buf_wd;
  logic              hit, take, load;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign ctr_ra      = in_data_i.pc[2 +: CIW] & CMask;
  assign buf_ra      = in_data_i.pc[2 +: BIW] & BMask;
  assign ctr_req_idx = req_q.pc[2 +: CIW] & CMask;
  assign buf_req_idx = req_q.pc[2 +: BIW] & BMask;

  // lookup on the registered read data
  assign hit  = buf_rd_q.valid && (buf_rd_q.tag == req_q.pc[PcW-1:2]);
  assign take = hit && (ctr_rd_q >= CtrTakenMin);

  always_comb begin
    if (req_q.was_taken) begin
      ctr_new = (ctr_rd_q == CtrMax) ? CtrMax : ctr_rd_q + 2'd1;
    end else begin
      ctr_new = (ctr_rd_q == CtrMin) ? CtrMin : ctr_rd_q - 2'd1;
    end
  end

  assign load = (state_q == ST_LOOKUP) && (req_q.action == ACT_PREDICT) &&
                (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ctr_we      = 1'b0;
    buf_we      = 1'b0;
    ctr_wa      = ctr_req_idx;
    buf_wa      = buf_req_idx;
    ctr_wd      = ctr_new;
    buf_wd      = '{valid: 1'b1, tag: req_q.pc[PcW-1:2], target: req_q.jump_target};
    unique case (state_q)
      ST_CLEAR: begin
        ctr_wa = clr_q[CIW-1:0];
        buf_wa = clr_q[BIW-1:0];
        ctr_wd = CtrReset;
        buf_wd = '{valid: 1'b0, tag: '0, target: '0};
        ctr_we = ({1'b0, clr_q} < CntDepth);
        buf_we = ({1'b0, clr_q} < BufDepth);
        clr_d  = clr_q + 1'b1;
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (req_q.action == ACT_UPDATE) begin
          ctr_we  = 1'b1;
          buf_we  = req_q.was_taken;
          state_d = ST_IDLE;
        end else if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d              = 1'b1;
      out_data_d.predict_taken = take;
      out_data_d.buffer_hit    = hit;
      out_data_d.next_pc       = take ? buf_rd_q.target : req_q.pc + PcStep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      req_q <= in_data_i;
    end
  end

  // direction counter memory
  always_ff @(posedge clk_i) begin
    if (ctr_we) begin
      ctr_mem[ctr_wa] <= ctr_wd;
    end
    if (accept) begin
      ctr_rd_q <= ctr_mem[ctr_ra];
    end
  end

  // target buffer memory
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_wa] <= buf_wd;
    end
    if (accept) begin
      buf_rd_q <= buf_mem[buf_ra];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bbp_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bbp_checker
// port-level checks on the branch predictor, bound to its top level
// ----------------------------------------------------------------------------
module bbp_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_stall_o,
  input wire bbp_pkg::bbp_in_t  in_data_i,
  input wire                    out_valid_o,
  input wire                    out_stall_i,
  input wire bbp_pkg::bbp_out_t out_data_o
);
  import bbp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one transaction in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while busy");

  // update gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.action == ACT_UPDATE)
    |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result from update");

  // predict gets a result when the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.action == ACT_PREDICT) && !out_valid_o
    |-> ##2 out_valid_o)
    else $error("predict result missing");

  // not-taken result falls through to pc plus four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.action == ACT_PREDICT) && !out_valid_o
    |-> ##2 (out_data_o.predict_taken ||
             (out_data_o.next_pc == $past(in_data_i.pc, 2) + PcStep)))
    else $error("wrong fall-through pc");

endmodule

bind bimodal_branch_predictor_btb_top bbp_checker u_bbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
